@@ rtl/core/gtrav_pkg.sv @@
// Package for the graph traversal block: word types, function codes,
// sequencer states and fixed field widths. No dependencies.
package gtrav_pkg;

  // Fixed field widths
  localparam int CFG_W       = 5;
  localparam int VTX_W       = 4;
  localparam int CNT_W       = 16;
  localparam int RES_W       = 5;
  localparam int MAX_RESULTS = 16;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 5'd16;

  // Function codes
  localparam logic [1:0] FN_ADD_DIR   = 2'd0;
  localparam logic [1:0] FN_ADD_UNDIR = 2'd1;
  localparam logic [1:0] FN_BFS       = 2'd2;
  localparam logic [1:0] FN_DFS       = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } req_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic             status;
    logic [CNT_W-1:0] edge_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_EDGE_RD2,
    S_EDGE_WR2,
    S_RESP,
    S_LIST_RD,
    S_ROW_RD,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

@@ rtl/core/gtrav_ffs.sv @@
// Find-first-set unit: lowest set bit of a candidate vector.
// Standalone, no package dependency.
module gtrav_ffs #(
  parameter int W  = 16,
  parameter int IW = 4
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  // Descending sweep, lowest set bit wins
  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

@@ rtl/core/graph_bfs_dfs_traversal.sv @@
// Channel  Signals                      Word     Direction
// cfg      cfg_we, cfg_wdata            -        in, vertex_count write, no stall
// req      req_valid, req_ready, req    req_t    in, edge add or search request
// rsp      rsp_valid, rsp_ready, rsp    rsp_t    out, status or visited vertex
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Edge add: source row read and write, reverse row too if undirected, then response;
// a rejected index skips to the response. BFS: list read, row read, scan per vertex;
// DFS: the same per push and pop; one row read port, one shared find-first unit.
// A full output register (rsp_valid high, rsp_ready low) stalls the sequencer.
// Synchronous active-high reset clears the adjacency row valid bits at once.
// Depends on gtrav_pkg and gtrav_ffs.
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [gtrav_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  gtrav_pkg::req_t           req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output gtrav_pkg::rsp_t           rsp
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  // Control registers
  gtrav_pkg::state_t            state, state_next;
  logic [gtrav_pkg::CFG_W-1:0]  vertex_count;
  logic [gtrav_pkg::CNT_W-1:0]  edges;
  logic                         pend_valid;
  logic [MAX_VERTICES-1:0]      row_valid;

  // Datapath registers
  logic [1:0]                   func_q;
  logic [VW-1:0]                src_q, dst_q;
  logic                         resp_err;
  logic [MAX_VERTICES-1:0]      visited;
  logic [NW-1:0]                head, tail;
  logic [VW-1:0]                pend_v;
  logic [gtrav_pkg::RES_W-1:0]  res_cnt;

  // Memories
  logic [MAX_VERTICES-1:0]      adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]      adj_rdata;
  logic                         adj_ok;
  logic [VW-1:0]                wl_mem [MAX_VERTICES];
  logic [VW-1:0]                wl_rdata;

  // Combinational controls
  logic                         accept, is_trav, is_bfs, s_ok, d_ok, out_free, res_full;
  logic [VW-1:0]                s_idx, d_idx;
  logic [MAX_VERTICES-1:0]      n_mask, row_eff, cand;
  logic                         found;
  logic [VW-1:0]                pick;
  logic                         visit_en, push_en, head_inc, pop, edge_inc, pend_clear;
  logic [VW-1:0]                visit_v;
  gtrav_pkg::rsp_t              push_word;
  logic                         wl_we, wl_rd_en, adj_rd_en, adj_we;
  logic [VW-1:0]                wl_wr_addr, wl_rd_addr, adj_rd_addr, adj_wr_addr, adj_wr_bit;

  // Request decode and index checks
  assign req_ready = (state == gtrav_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_trav   = (req.func == gtrav_pkg::FN_BFS) || (req.func == gtrav_pkg::FN_DFS);
  assign is_bfs    = (func_q == gtrav_pkg::FN_BFS);
  assign s_idx     = VW'(req.src_vertex);
  assign d_idx     = VW'(req.dst_vertex);
  assign s_ok      = (gtrav_pkg::CFG_W'(req.src_vertex) < vertex_count) &&
                     (int'(req.src_vertex) < MAX_VERTICES);
  assign d_ok      = (gtrav_pkg::CFG_W'(req.dst_vertex) < vertex_count) &&
                     (int'(req.dst_vertex) < MAX_VERTICES);
  assign out_free  = !rsp_valid || rsp_ready;
  // Result count belongs to the running search; a new search counts its start vertex
  assign res_full  = (state != gtrav_pkg::S_IDLE) &&
                     (res_cnt == gtrav_pkg::RES_W'(gtrav_pkg::MAX_RESULTS));

  // Vertices in use
  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      n_mask[v] = (v < int'(vertex_count));
    end
  end

  // Neighbor candidates: row minus visited, within range
  assign row_eff = adj_ok ? adj_rdata : '0;
  assign cand    = row_eff & ~visited & n_mask;

  gtrav_ffs #(
    .W  (MAX_VERTICES),
    .IW (VW)
  ) u_ffs (
    .vec   (cand),
    .found (found),
    .idx   (pick)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gtrav_pkg::S_IDLE: begin
        if (accept) begin
          if (is_trav ? !s_ok : !(s_ok && d_ok)) begin
            state_next = gtrav_pkg::S_RESP;
          end else if (is_trav) begin
            state_next = gtrav_pkg::S_LIST_RD;
          end else begin
            state_next = gtrav_pkg::S_EDGE_RD;
          end
        end
      end
      gtrav_pkg::S_EDGE_RD:  state_next = gtrav_pkg::S_EDGE_WR;
      gtrav_pkg::S_EDGE_WR: begin
        state_next = (func_q == gtrav_pkg::FN_ADD_UNDIR) ? gtrav_pkg::S_EDGE_RD2
                                                          : gtrav_pkg::S_RESP;
      end
      gtrav_pkg::S_EDGE_RD2: state_next = gtrav_pkg::S_EDGE_WR2;
      gtrav_pkg::S_EDGE_WR2: state_next = gtrav_pkg::S_RESP;
      gtrav_pkg::S_RESP: begin
        if (out_free) state_next = gtrav_pkg::S_IDLE;
      end
      gtrav_pkg::S_LIST_RD:  state_next = gtrav_pkg::S_ROW_RD;
      gtrav_pkg::S_ROW_RD:   state_next = gtrav_pkg::S_SCAN;
      gtrav_pkg::S_SCAN: begin
        if (is_bfs) begin
          if (!found) begin
            state_next = (head < tail) ? gtrav_pkg::S_LIST_RD : gtrav_pkg::S_FINISH;
          end
        end else if (found) begin
          if (visit_en) state_next = gtrav_pkg::S_LIST_RD;
        end else begin
          state_next = (tail == NW'(1)) ? gtrav_pkg::S_FINISH : gtrav_pkg::S_LIST_RD;
        end
      end
      gtrav_pkg::S_FINISH: begin
        if (out_free) state_next = gtrav_pkg::S_IDLE;
      end
      default: state_next = gtrav_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    visit_en    = 1'b0;
    visit_v     = '0;
    push_en     = 1'b0;
    push_word   = '0;
    head_inc    = 1'b0;
    pop         = 1'b0;
    edge_inc    = 1'b0;
    pend_clear  = 1'b0;
    wl_rd_en    = 1'b0;
    wl_rd_addr  = '0;
    adj_rd_en   = 1'b0;
    adj_rd_addr = '0;
    adj_we      = 1'b0;
    adj_wr_addr = '0;
    adj_wr_bit  = '0;
    unique case (state)
      gtrav_pkg::S_IDLE: begin
        if (accept && is_trav && s_ok) begin
          visit_en = 1'b1;
          visit_v  = s_idx;
        end
      end
      gtrav_pkg::S_EDGE_RD: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = src_q;
      end
      gtrav_pkg::S_EDGE_WR: begin
        adj_we      = 1'b1;
        adj_wr_addr = src_q;
        adj_wr_bit  = dst_q;
        edge_inc    = 1'b1;
      end
      gtrav_pkg::S_EDGE_RD2: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = dst_q;
      end
      gtrav_pkg::S_EDGE_WR2: begin
        adj_we      = 1'b1;
        adj_wr_addr = dst_q;
        adj_wr_bit  = src_q;
        edge_inc    = 1'b1;
      end
      gtrav_pkg::S_RESP: begin
        if (out_free) begin
          push_en              = 1'b1;
          push_word.last       = 1'b1;
          push_word.status     = resp_err;
          push_word.edge_count = edges;
        end
      end
      gtrav_pkg::S_LIST_RD: begin
        wl_rd_en   = 1'b1;
        wl_rd_addr = is_bfs ? VW'(head) : VW'(tail - NW'(1));
        head_inc   = is_bfs;
      end
      gtrav_pkg::S_ROW_RD: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = wl_rdata;
      end
      gtrav_pkg::S_SCAN: begin
        if (found) begin
          if (res_full || out_free) begin
            visit_en = 1'b1;
            visit_v  = pick;
          end
        end else begin
          pop = !is_bfs;
        end
      end
      gtrav_pkg::S_FINISH: begin
        if (out_free) begin
          push_en              = 1'b1;
          pend_clear           = 1'b1;
          push_word.vertex     = gtrav_pkg::VTX_W'(pend_v);
          push_word.last       = 1'b1;
          push_word.edge_count = edges;
        end
      end
      default: ;
    endcase
    // Emitting a new visit retires the held one as a non-final word
    if (visit_en && !res_full && pend_valid) begin
      push_en              = 1'b1;
      push_word.vertex     = gtrav_pkg::VTX_W'(pend_v);
      push_word.last       = 1'b0;
      push_word.status     = 1'b0;
      push_word.edge_count = edges;
    end
  end

  // Work list write port; the start vertex always lands in entry zero
  assign wl_we      = visit_en &&
                      ((state == gtrav_pkg::S_IDLE) || (int'(tail) < MAX_VERTICES));
  assign wl_wr_addr = (state == gtrav_pkg::S_IDLE) ? '0 : VW'(tail);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gtrav_pkg::S_IDLE;
      vertex_count <= gtrav_pkg::VERTEX_COUNT_RST;
      edges        <= '0;
      pend_valid   <= 1'b0;
      row_valid    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_wdata;
      if (edge_inc && (edges != '1)) edges <= edges + gtrav_pkg::CNT_W'(1);
      if (visit_en && !res_full) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (adj_we) row_valid[adj_wr_addr] <= 1'b1;
      if (push_en) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture and traversal bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= req.func;
      src_q    <= s_idx;
      dst_q    <= d_idx;
      resp_err <= is_trav ? !s_ok : !(s_ok && d_ok);
    end
    if (state == gtrav_pkg::S_IDLE) begin
      if (visit_en) begin
        visited <= ONE_BIT << visit_v;
        head    <= '0;
        tail    <= NW'(1);
        pend_v  <= visit_v;
        res_cnt <= gtrav_pkg::RES_W'(1);
      end
    end else begin
      if (visit_en) begin
        visited <= visited | (ONE_BIT << visit_v);
        tail    <= tail + NW'(1);
        if (!res_full) begin
          pend_v  <= visit_v;
          res_cnt <= res_cnt + gtrav_pkg::RES_W'(1);
        end
      end else if (pop) begin
        tail <= tail - NW'(1);
      end
      if (head_inc) head <= head + NW'(1);
    end
    if (push_en) rsp <= push_word;
  end

  // Adjacency rows: one read port, one write port
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wr_addr] <= row_eff | (ONE_BIT << adj_wr_bit);
    if (adj_rd_en) begin
      adj_rdata <= adj_mem[adj_rd_addr];
      adj_ok    <= row_valid[adj_rd_addr] && !(adj_we && (adj_wr_addr == adj_rd_addr));
    end
  end

  // Work list: queue for BFS, stack for DFS
  always_ff @(posedge clk) begin
    if (wl_we) wl_mem[wl_wr_addr] <= visit_v;
    if (wl_rd_en) wl_rdata <= wl_mem[wl_rd_addr];
  end

`ifndef SYNTH
  // Final word of a search carries last
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == gtrav_pkg::S_FINISH && out_free) |=> (rsp_valid && rsp.last))
    else $error("search end did not deliver a last word");

  // Work list tail stays within the vertex limit; each vertex enters at most once
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gtrav_pkg::S_LIST_RD || state == gtrav_pkg::S_ROW_RD ||
     state == gtrav_pkg::S_SCAN) |-> (int'(tail) <= MAX_VERTICES))
    else $error("work list tail beyond vertex limit");

  // A held result exists for the whole of a search
  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    (state == gtrav_pkg::S_LIST_RD || state == gtrav_pkg::S_ROW_RD ||
     state == gtrav_pkg::S_SCAN || state == gtrav_pkg::S_FINISH) |-> pend_valid)
    else $error("search running without a held result");

  // Nothing is held once the sequencer is back to idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == gtrav_pkg::S_IDLE) |-> !pend_valid)
    else $error("held result left over in idle");
`endif

endmodule
